### rtl/fcau_pkg.sv
// shared types, constants and helper functions of the float compare/arith unit
// no dependencies; every other rtl file refers to this package by scoped names
package fcau_pkg;

  // operation codes carried on the input tuser
  localparam logic [3:0] OP_EQ  = 4'd0;
  localparam logic [3:0] OP_NE  = 4'd1;
  localparam logic [3:0] OP_LT  = 4'd2;
  localparam logic [3:0] OP_LE  = 4'd3;
  localparam logic [3:0] OP_GT  = 4'd4;
  localparam logic [3:0] OP_GE  = 4'd5;
  localparam logic [3:0] OP_ADD = 4'd6;
  localparam logic [3:0] OP_SUB = 4'd7;
  localparam logic [3:0] OP_MUL = 4'd8;
  localparam logic [3:0] OP_DIV = 4'd9;
  localparam logic [3:0] OP_OR  = 4'd10;
  localparam logic [3:0] OP_AND = 4'd11;

  localparam logic [31:0] QNAN  = 32'h7FC0_0000;
  localparam logic [31:0] ONE_F = 32'h3F80_0000;
  localparam logic [31:0] INF_F = 32'h7F80_0000;

  // quotient bits resolved in each divider stage, and number of such stages
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 7;

  typedef enum logic [1:0] {
    KIND_SPEC,
    KIND_ADD,
    KIND_MUL,
    KIND_DIV
  } kind_t;

  // unpacked operands, significands normalised to a leading one at bit 23
  typedef struct packed {
    kind_t              kind;
    logic [31:0]        spec_val;
    logic               sign_a;
    logic               sign_b;
    logic signed [10:0] exp_a;
    logic signed [10:0] exp_b;
    logic [23:0]        man_a;
    logic [23:0]        man_b;
  } unp_t;

  // working beat from the setup stage to rounding
  typedef struct packed {
    kind_t              kind;
    logic [31:0]        spec_val;
    logic               sign;
    logic               eff_sub;
    logic signed [10:0] expo;
    logic [27:0]        mant;
    logic               sticky;
    logic [25:0]        rem;
    logic [23:0]        aux;
    logic [4:0]         shamt;
  } work_t;

  // position of the highest set bit, zero for a zero word
  function automatic logic [4:0] msb_pos(input logic [27:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

### rtl/fcau_unpack.sv
// stage 1: operand classification, comparisons, special results, prenormalising
// uses fcau_pkg
module fcau_unpack (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [3:0]       mode,
  input  logic [31:0]      left_bits,
  input  logic [31:0]      right_bits,
  output logic             out_valid,
  input  logic             out_ready,
  output fcau_pkg::unp_t   out_data
);

  fcau_pkg::unp_t d;
  logic nan_l, nan_r, inf_l, inf_r, zero_l, zero_r, unord;
  logic [31:0] key_l, key_r;
  logic eq, lt, sb_eff, sp;
  logic [23:0] ml, mr;
  logic [7:0] el, er;
  logic [4:0] lz_l, lz_r;

  always_comb begin
    nan_l  = left_bits[30:0] > fcau_pkg::INF_F[30:0];
    nan_r  = right_bits[30:0] > fcau_pkg::INF_F[30:0];
    inf_l  = left_bits[30:0] == fcau_pkg::INF_F[30:0];
    inf_r  = right_bits[30:0] == fcau_pkg::INF_F[30:0];
    zero_l = left_bits[30:0] == 31'd0;
    zero_r = right_bits[30:0] == 31'd0;
    unord  = nan_l | nan_r;
    key_l  = left_bits[31] ? (32'd0 - {1'b0, left_bits[30:0]}) : {1'b0, left_bits[30:0]};
    key_r  = right_bits[31] ? (32'd0 - {1'b0, right_bits[30:0]}) : {1'b0, right_bits[30:0]};
    eq     = key_l == key_r;
    lt     = $signed(key_l) < $signed(key_r);
    sb_eff = right_bits[31] ^ (mode == fcau_pkg::OP_SUB);
    sp     = left_bits[31] ^ right_bits[31];

    el   = (left_bits[30:23] == 8'd0) ? 8'd1 : left_bits[30:23];
    er   = (right_bits[30:23] == 8'd0) ? 8'd1 : right_bits[30:23];
    ml   = {(left_bits[30:23] != 8'd0), left_bits[22:0]};
    mr   = {(right_bits[30:23] != 8'd0), right_bits[22:0]};
    lz_l = 5'd23 - fcau_pkg::msb_pos({4'd0, ml});
    lz_r = 5'd23 - fcau_pkg::msb_pos({4'd0, mr});

    d.sign_a = left_bits[31];
    d.sign_b = (mode == fcau_pkg::OP_SUB) ? sb_eff : right_bits[31];
    d.man_a  = ml << lz_l;
    d.man_b  = mr << lz_r;
    d.exp_a  = $signed({3'd0, el}) - 11'sd127 - $signed({6'd0, lz_l});
    d.exp_b  = $signed({3'd0, er}) - 11'sd127 - $signed({6'd0, lz_r});
    d.kind     = fcau_pkg::KIND_SPEC;
    d.spec_val = '0;

    unique case (mode) inside
      fcau_pkg::OP_EQ: d.spec_val = (!unord && eq) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_NE: d.spec_val = (unord || !eq) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_LT: d.spec_val = (!unord && lt) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_LE: d.spec_val = (!unord && (lt || eq)) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_GT: d.spec_val = (!unord && !lt && !eq) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_GE: d.spec_val = (!unord && !lt) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_OR: d.spec_val = (!zero_l || !zero_r) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_AND: d.spec_val = (!zero_l && !zero_r) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_ADD, fcau_pkg::OP_SUB: begin
        if (unord) d.spec_val = fcau_pkg::QNAN;
        else if (inf_l) d.spec_val = (inf_r && left_bits[31] != sb_eff) ? fcau_pkg::QNAN
                                                                         : left_bits;
        else if (inf_r) d.spec_val = {sb_eff, right_bits[30:0]};
        else if (zero_l && zero_r) d.spec_val = {left_bits[31] & sb_eff, 31'd0};
        else if (zero_l) d.spec_val = {sb_eff, right_bits[30:0]};
        else if (zero_r) d.spec_val = left_bits;
        else d.kind = fcau_pkg::KIND_ADD;
      end
      fcau_pkg::OP_MUL: begin
        if (unord) d.spec_val = fcau_pkg::QNAN;
        else if (inf_l || inf_r) d.spec_val = (zero_l || zero_r) ? fcau_pkg::QNAN
                                                                 : {sp, fcau_pkg::INF_F[30:0]};
        else if (zero_l || zero_r) d.spec_val = {sp, 31'd0};
        else d.kind = fcau_pkg::KIND_MUL;
      end
      fcau_pkg::OP_DIV: begin
        if (unord) d.spec_val = fcau_pkg::QNAN;
        else if (inf_l) d.spec_val = inf_r ? fcau_pkg::QNAN : {sp, fcau_pkg::INF_F[30:0]};
        else if (inf_r) d.spec_val = {sp, 31'd0};
        else if (zero_r) d.spec_val = zero_l ? fcau_pkg::QNAN : {sp, fcau_pkg::INF_F[30:0]};
        else if (zero_l) d.spec_val = {sp, 31'd0};
        else d.kind = fcau_pkg::KIND_DIV;
      end
      default: d.spec_val = right_bits;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= d;
    end
  end

endmodule

### rtl/fcau_prep.sv
// stage 2: significand product, add operand ordering, divider set-up
// uses fcau_pkg
module fcau_prep (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fcau_pkg::unp_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fcau_pkg::work_t  out_data
);

  fcau_pkg::work_t d;
  logic [47:0] prod;
  logic a_big, ge;
  logic signed [10:0] diff;

  always_comb begin
    prod  = in_data.man_a * in_data.man_b;
    a_big = (in_data.exp_a > in_data.exp_b) ||
            ((in_data.exp_a == in_data.exp_b) && (in_data.man_a >= in_data.man_b));
    diff  = a_big ? (in_data.exp_a - in_data.exp_b) : (in_data.exp_b - in_data.exp_a);
    ge    = in_data.man_a >= in_data.man_b;

    d.kind     = in_data.kind;
    d.spec_val = in_data.spec_val;
    d.sign     = in_data.sign_a ^ in_data.sign_b;
    d.eff_sub  = in_data.sign_a != in_data.sign_b;
    d.expo     = '0;
    d.mant     = '0;
    d.sticky   = 1'b0;
    d.rem      = '0;
    d.aux      = '0;
    d.shamt    = (diff > 11'sd31) ? 5'd31 : diff[4:0];

    case (in_data.kind)
      fcau_pkg::KIND_ADD: begin
        d.sign = a_big ? in_data.sign_a : in_data.sign_b;
        d.expo = a_big ? in_data.exp_a : in_data.exp_b;
        d.mant = {1'b0, (a_big ? in_data.man_a : in_data.man_b), 3'd0};
        d.aux  = a_big ? in_data.man_b : in_data.man_a;
      end
      fcau_pkg::KIND_MUL: begin
        if (prod[47]) begin
          d.expo   = in_data.exp_a + in_data.exp_b + 11'sd1;
          d.mant   = prod[47:20];
          d.sticky = |prod[19:0];
        end else begin
          d.expo   = in_data.exp_a + in_data.exp_b;
          d.mant   = prod[46:19];
          d.sticky = |prod[18:0];
        end
      end
      fcau_pkg::KIND_DIV: begin
        d.rem  = ge ? {2'd0, in_data.man_a} : {1'b0, in_data.man_a, 1'b0};
        d.expo = in_data.exp_a - in_data.exp_b - (ge ? 11'sd0 : 11'sd1);
        d.aux  = in_data.man_b;
      end
      default: ;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= d;
    end
  end

endmodule

### rtl/fcau_div_step.sv
// one divider stage: a few restoring quotient steps, other beats pass untouched
// uses fcau_pkg
module fcau_div_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fcau_pkg::work_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fcau_pkg::work_t  out_data
);

  fcau_pkg::work_t d;
  logic q;

  always_comb begin
    d = in_data;
    q = 1'b0;
    if (in_data.kind == fcau_pkg::KIND_DIV) begin
      for (int i = 0; i < fcau_pkg::DIV_STEPS; i++) begin
        q = d.rem >= {2'd0, d.aux};
        if (q) d.rem = d.rem - {2'd0, d.aux};
        d.mant = {d.mant[26:0], q};
        d.rem  = {d.rem[24:0], 1'b0};
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= d;
    end
  end

endmodule

### rtl/fcau_align.sv
// alignment and significand add/subtract, divider remainder to sticky
// uses fcau_pkg
module fcau_align (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fcau_pkg::work_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fcau_pkg::work_t  out_data
);

  fcau_pkg::work_t d;
  logic [57:0] wide;
  logic [26:0] b;
  logic st;

  always_comb begin
    d    = in_data;
    wide = {in_data.aux, 3'd0, 31'd0} >> in_data.shamt;
    b    = wide[57:31];
    st   = |wide[30:0];
    case (in_data.kind)
      fcau_pkg::KIND_ADD: begin
        d.sticky = st;
        if (in_data.eff_sub) d.mant = in_data.mant - {1'b0, b} - {27'd0, st};
        else d.mant = in_data.mant + {1'b0, b};
      end
      fcau_pkg::KIND_DIV: d.sticky = in_data.rem != 26'd0;
      default: ;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= d;
    end
  end

endmodule

### rtl/fcau_norm.sv
// sum normalisation: leading-one search and left shift, exact zero sums
// uses fcau_pkg
module fcau_norm (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fcau_pkg::work_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fcau_pkg::work_t  out_data
);

  fcau_pkg::work_t d;
  logic [4:0] p;

  always_comb begin
    d = in_data;
    p = fcau_pkg::msb_pos(in_data.mant);
    if (in_data.kind == fcau_pkg::KIND_ADD) begin
      if (in_data.mant == 28'd0 && !in_data.sticky) begin
        d.kind     = fcau_pkg::KIND_SPEC;
        d.spec_val = '0;
      end else begin
        d.mant = in_data.mant << (5'd27 - p);
        d.expo = in_data.expo + $signed({6'd0, p}) - 11'sd26;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= d;
    end
  end

endmodule

### rtl/fcau_round.sv
// final stage: gradual underflow shift, round to nearest even, packing
// uses fcau_pkg
module fcau_round (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fcau_pkg::work_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      result
);

  logic ovf, tiny, g, rest, inc;
  logic signed [10:0] shd, ebias;
  logic [4:0] sh;
  logic [59:0] wide;
  logic [27:0] m2;
  logic [23:0] q;
  logic [30:0] base, r;
  logic [31:0] res;

  always_comb begin
    ovf   = in_data.expo > 11'sd127;
    tiny  = in_data.expo < -11'sd126;
    shd   = -11'sd126 - in_data.expo;
    sh    = !tiny ? 5'd0 : ((shd > 11'sd31) ? 5'd31 : shd[4:0]);
    wide  = {in_data.mant, 32'd0} >> sh;
    m2    = wide[59:32];
    q     = m2[27:4];
    g     = m2[3];
    rest  = (|m2[2:0]) | (|wide[31:0]) | in_data.sticky;
    inc   = g & (rest | q[0]);
    ebias = in_data.expo + 11'sd126;
    base  = tiny ? 31'd0 : {ebias[7:0], 23'd0};
    r     = base + {7'd0, q} + {30'd0, inc};
    if (ovf || r >= fcau_pkg::INF_F[30:0]) r = fcau_pkg::INF_F[30:0];
    res = (in_data.kind == fcau_pkg::KIND_SPEC) ? in_data.spec_val : {in_data.sign, r};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      result <= res;
    end
  end

endmodule

### rtl/float_compare_arith_unit.sv
// binary32 compare / arithmetic unit, twelve register stages deep
// every operation passes through all stages, from input beat to result beat
// throughput: one beat per cycle unless the output stalls; the divider is unrolled
//   over seven stages of four quotient bits each, so no operation holds the pipe
// reset: synchronous rst clears all stage valid bits, no state beyond that
module float_compare_arith_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // left_bits [31:0], right_bits [63:32]
  input  logic [3:0]  s_tuser,   // mode [3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // result_bits [31:0]
);

  // per-stage handshake: a stage loads when it is empty or its beat moves on,
  // so bubbles close up and a stall at the output backs up one stage at a time

  fcau_pkg::unp_t  unp_data;
  logic            unp_valid, unp_ready;

  // divider chain: index 0 is the set-up stage output, index DIV_STAGES the last
  fcau_pkg::work_t div_data  [fcau_pkg::DIV_STAGES+1];
  logic            div_valid [fcau_pkg::DIV_STAGES+1];
  logic            div_ready [fcau_pkg::DIV_STAGES+1];

  fcau_pkg::work_t aln_data, nrm_data;
  logic            aln_valid, aln_ready, nrm_valid, nrm_ready;

  // stage 1: classification, comparisons, constant results, prenormalising
  fcau_unpack u_unpack (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mode       (s_tuser),
    .left_bits  (s_tdata[31:0]),
    .right_bits (s_tdata[63:32]),
    .out_valid  (unp_valid),
    .out_ready  (unp_ready),
    .out_data   (unp_data)
  );

  // stage 2: 24x24 product, add ordering, divider set-up
  fcau_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (unp_valid),
    .in_ready  (unp_ready),
    .in_data   (unp_data),
    .out_valid (div_valid[0]),
    .out_ready (div_ready[0]),
    .out_data  (div_data[0])
  );

  // stages 3 to 9: restoring division, 28 quotient bits in all
  for (genvar k = 0; k < fcau_pkg::DIV_STAGES; k++) begin : g_div
    fcau_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[k]),
      .in_ready  (div_ready[k]),
      .in_data   (div_data[k]),
      .out_valid (div_valid[k+1]),
      .out_ready (div_ready[k+1]),
      .out_data  (div_data[k+1])
    );
  end

  // stage 10: add alignment and sum
  fcau_align u_align (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid[fcau_pkg::DIV_STAGES]),
    .in_ready  (div_ready[fcau_pkg::DIV_STAGES]),
    .in_data   (div_data[fcau_pkg::DIV_STAGES]),
    .out_valid (aln_valid),
    .out_ready (aln_ready),
    .out_data  (aln_data)
  );

  // stage 11: normalise sums
  fcau_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (aln_valid),
    .in_ready  (aln_ready),
    .in_data   (aln_data),
    .out_valid (nrm_valid),
    .out_ready (nrm_ready),
    .out_data  (nrm_data)
  );

  // stage 12: rounding; its register is the output register
  fcau_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nrm_valid),
    .in_ready  (nrm_ready),
    .in_data   (nrm_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (m_tdata)
  );

endmodule

### tb/tb.sv
// self-checking testbench for float_compare_arith_unit: directed special values, then
// random operations under several idle/stall mixes; depends on rtl/fcau_pkg.sv and the rtl
`timescale 1ns / 100ps
module tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_LEN     = 200;

  // a beat sent to the unit together with the result it must give
  typedef struct {
    logic [3:0]  op;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic [31:0] res;
  } float_op_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // left_bits [31:0], right_bits [63:32]
  logic [3:0]  s_tuser = '0;   // mode [3:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // result_bits [31:0]

  float_op_t   pending_results[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req_cnt = 0;
  int          hold_ack_cnt = 0;
  int          hold_cycles = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_errors = 0;
  int          cycle_cnt = 0;

  float_compare_arith_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // binary32 predictor
  // ---------------------------------------------------------------------------
  function automatic bit f_is_nan(logic [31:0] x);
    return x[30:0] > fcau_pkg::INF_F[30:0];
  endfunction

  function automatic bit f_is_inf(logic [31:0] x);
    return x[30:0] == fcau_pkg::INF_F[30:0];
  endfunction

  function automatic bit f_is_zero(logic [31:0] x);
    return x[30:0] == '0;
  endfunction

  // signed line for ordering, both zeros map to 0
  function automatic longint order_pos(logic [31:0] x);
    longint mag;
    mag = longint'(x[30:0]);
    return x[31] ? -mag : mag;
  endfunction

  // value = sig * 2^(ex-150), hidden bit restored for normals
  function automatic void split_float(input logic [31:0] x, output int ex,
                                      output logic [63:0] sig);
    if (x[30:23] == 8'd0) begin
      ex = 1;
      sig = {41'd0, x[22:0]};
    end else begin
      ex = int'(x[30:23]);
      sig = {40'd0, 1'b1, x[22:0]};
    end
  endfunction

  // nearest-even rounding of sig * 2^ex with an optional sticky remainder
  function automatic logic [31:0] round_to_single(bit sgn, int ex, logic [63:0] sig,
                                                  bit sticky);
    int          p;
    int          top_e;
    int          shift;
    logic [31:0] base;
    logic [31:0] r;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    p = 63;
    while (p > 0 && !sig[p]) p--;
    top_e = ex + p;
    if (top_e + 127 > 254) return {sgn, fcau_pkg::INF_F[30:0]};
    if (top_e < -126) begin
      shift = -149 - ex;
      base = '0;
    end else begin
      shift = p - 23;
      base = 32'(top_e + 126) << 23;
    end
    if (shift <= 0) begin
      q = sig << (-shift);
    end else if (shift > 64) begin
      q = '0;
    end else begin
      if (shift == 64) begin
        q = '0;
        rem = sig;
      end else begin
        q = sig >> shift;
        rem = sig & ((64'd1 << shift) - 64'd1);
      end
      half = 64'd1 << (shift - 1);
      if (rem > half || (rem == half && (sticky || q[0]))) q++;
    end
    r = base + q[31:0];
    if (r >= fcau_pkg::INF_F) r = fcau_pkg::INF_F;
    return {sgn, 31'd0} | r;
  endfunction

  function automatic logic [31:0] float_sum(logic [31:0] a, logic [31:0] b);
    bit          sa;
    bit          sb;
    bit          tb_s;
    bit          sticky;
    int          ea;
    int          eb;
    int          te;
    int          d;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] m;
    sa = a[31];
    sb = b[31];
    sticky = 1'b0;
    if (f_is_nan(a) || f_is_nan(b)) return fcau_pkg::QNAN;
    if (f_is_inf(a)) return (f_is_inf(b) && sa != sb) ? fcau_pkg::QNAN : a;
    if (f_is_inf(b)) return b;
    split_float(a, ea, ma);
    split_float(b, eb, mb);
    if (eb > ea) begin
      te = ea; ea = eb; eb = te;
      m = ma; ma = mb; mb = m;
      tb_s = sa; sa = sb; sb = tb_s;
    end
    ma = ma << 30;
    mb = mb << 30;
    d = ea - eb;
    if (d >= 62) begin
      sticky = (mb != 0);
      mb = '0;
    end else if (d > 0) begin
      sticky = (mb & ((64'd1 << d) - 64'd1)) != 0;
      mb = mb >> d;
    end
    if (sa == sb) begin
      m = ma + mb;
    end else if (ma >= mb) begin
      m = ma - mb;
      if (sticky) m = m - 64'd1;
    end else begin
      m = mb - ma;
      sa = sb;
    end
    if (m == 0 && !sticky) return (a & b) & 32'h8000_0000;
    return round_to_single(sa, ea - 180, m, sticky);
  endfunction

  function automatic logic [31:0] float_product(logic [31:0] a, logic [31:0] b);
    bit          sgn;
    int          ea;
    int          eb;
    logic [63:0] ma;
    logic [63:0] mb;
    sgn = a[31] ^ b[31];
    if (f_is_nan(a) || f_is_nan(b)) return fcau_pkg::QNAN;
    if (f_is_inf(a) || f_is_inf(b)) begin
      if (f_is_zero(a) || f_is_zero(b)) return fcau_pkg::QNAN;
      return {sgn, fcau_pkg::INF_F[30:0]};
    end
    if (f_is_zero(a) || f_is_zero(b)) return {sgn, 31'd0};
    split_float(a, ea, ma);
    split_float(b, eb, mb);
    return round_to_single(sgn, ea + eb - 300, ma * mb, 1'b0);
  endfunction

  function automatic logic [31:0] float_quotient(logic [31:0] a, logic [31:0] b);
    bit          sgn;
    int          ea;
    int          eb;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] num;
    sgn = a[31] ^ b[31];
    if (f_is_nan(a) || f_is_nan(b)) return fcau_pkg::QNAN;
    if (f_is_inf(a)) return f_is_inf(b) ? fcau_pkg::QNAN : {sgn, fcau_pkg::INF_F[30:0]};
    if (f_is_inf(b)) return {sgn, 31'd0};
    if (f_is_zero(b)) return f_is_zero(a) ? fcau_pkg::QNAN : {sgn, fcau_pkg::INF_F[30:0]};
    if (f_is_zero(a)) return {sgn, 31'd0};
    split_float(a, ea, ma);
    split_float(b, eb, mb);
    while (ma < 64'h80_0000) begin ma = ma << 1; ea--; end
    while (mb < 64'h80_0000) begin mb = mb << 1; eb--; end
    num = ma << 40;
    return round_to_single(sgn, ea - eb - 40, num / mb, (num % mb) != 0);
  endfunction

  function automatic logic [31:0] predict_result(logic [3:0] op, logic [31:0] l,
                                                 logic [31:0] r);
    bit     unord;
    longint kl;
    longint kr;
    unord = f_is_nan(l) || f_is_nan(r);
    kl = order_pos(l);
    kr = order_pos(r);
    case (op)
      fcau_pkg::OP_EQ:  return (!unord && kl == kr) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_NE:  return (unord || kl != kr) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_LT:  return (!unord && kl < kr) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_LE:  return (!unord && kl <= kr) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_GT:  return (!unord && kl > kr) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_GE:  return (!unord && kl >= kr) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_ADD: return float_sum(l, r);
      fcau_pkg::OP_SUB: return float_sum(l, r ^ 32'h8000_0000);
      fcau_pkg::OP_MUL: return float_product(l, r);
      fcau_pkg::OP_DIV: return float_quotient(l, r);
      fcau_pkg::OP_OR:  return (!f_is_zero(l) || !f_is_zero(r)) ? fcau_pkg::ONE_F : '0;
      fcau_pkg::OP_AND: return (!f_is_zero(l) && !f_is_zero(r)) ? fcau_pkg::ONE_F : '0;
      default: return r;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side: one beat per call, optional idle cycles in front of it
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic [3:0] op, input logic [31:0] l, input logic [31:0] r);
    float_op_t item;
    // idle gaps drop tvalid at the falling edge, never within a held beat
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {r, l};
    do @(posedge clk); while (!s_tready);
    item.op = op;
    item.lhs = l;
    item.rhs = r;
    item.res = predict_result(op, l, r);
    pending_results.push_back(item);
    n_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_all_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // operand drawn from several classes so specials and edge exponents appear often
  function automatic logic [31:0] pick_operand();
    logic [31:0] specials[12];
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
                 32'h807F_FFFF, 32'h7F7F_FFFF, 32'h0080_0000, 32'h3F80_0000};
    case ($urandom_range(9))
      0:       return specials[$urandom_range(11)];
      1:       return {1'($urandom), 8'd0, 23'($urandom)};
      2:       return {1'($urandom), 8'($urandom_range(253, 254)), 23'($urandom)};
      3, 4:    return {1'($urandom), 8'($urandom_range(100, 155)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // right operand, often close to the left one to reach cancellation and ties
  function automatic logic [31:0] pick_partner(logic [31:0] l);
    case ($urandom_range(5))
      0:       return l ^ 32'h8000_0000;
      1:       return l ^ 32'($urandom_range(7));
      2:       return {~l[31], l[30:23] - 8'($urandom_range(3)), 23'($urandom)};
      default: return pick_operand();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls plus a long hold on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt = hold_req_cnt;
      hold_cycles = HOLD_LEN;
    end
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    float_op_t exp_item;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat %h", m_tdata);
      end else begin
        exp_item = pending_results.pop_front();
        n_checked++;
        if (m_tdata !== exp_item.res) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch op %0d l %h r %h: expected %h got %h", exp_item.op,
                     exp_item.lhs, exp_item.rhs, exp_item.res, m_tdata);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // every operation at least once, plus signed zeros, nan, infinities, division by zero,
  // exact cancellation, overflow, subnormal underflow and the unknown codes
  task automatic test_directed();
    send_op(fcau_pkg::OP_EQ,  32'h0000_0000, 32'h8000_0000);
    send_op(fcau_pkg::OP_NE,  32'h7FC0_0000, 32'h7FC0_0000);
    send_op(fcau_pkg::OP_LT,  32'hFF80_0000, 32'h7F80_0000);
    send_op(fcau_pkg::OP_LE,  32'h7FC0_0001, 32'h3F80_0000);
    send_op(fcau_pkg::OP_GT,  32'h0000_0001, 32'h8000_0000);
    send_op(fcau_pkg::OP_GE,  32'h8000_0000, 32'h0000_0000);
    send_op(fcau_pkg::OP_ADD, 32'h3F80_0000, 32'hBF80_0000);
    send_op(fcau_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000);
    send_op(fcau_pkg::OP_ADD, 32'h7F80_0000, 32'hFF80_0000);
    send_op(fcau_pkg::OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    send_op(fcau_pkg::OP_SUB, 32'h0080_0000, 32'h007F_FFFF);
    send_op(fcau_pkg::OP_SUB, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(fcau_pkg::OP_MUL, 32'h0000_0000, 32'hFF80_0000);
    send_op(fcau_pkg::OP_MUL, 32'h0000_0001, 32'h3F00_0000);
    send_op(fcau_pkg::OP_MUL, 32'h7F7F_FFFF, 32'hC000_0000);
    send_op(fcau_pkg::OP_DIV, 32'h3F80_0000, 32'h8000_0000);
    send_op(fcau_pkg::OP_DIV, 32'h0000_0000, 32'h0000_0000);
    send_op(fcau_pkg::OP_DIV, 32'h7F80_0000, 32'hFF80_0000);
    send_op(fcau_pkg::OP_DIV, 32'h0000_0001, 32'h4B00_0000);
    send_op(fcau_pkg::OP_OR,  32'h8000_0000, 32'h0000_0000);
    send_op(fcau_pkg::OP_OR,  32'h0000_0000, 32'h7FC0_0000);
    send_op(fcau_pkg::OP_AND, 32'hFFFF_FFFF, 32'h0000_0001);
    send_op(fcau_pkg::OP_AND, 32'h3F80_0000, 32'h8000_0000);
    send_op(4'd12,  32'h1234_5678, 32'hFFFF_FFFF);
    send_op(4'd15,  32'hFFFF_FFFF, 32'h0000_0000);
    stop_sending();
  endtask

  task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
    logic [31:0] l;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_items) begin
      l = pick_operand();
      send_op(4'($urandom_range(15)), l, pick_partner(l));
    end
    stop_sending();
  endtask

  // long receiver hold while the sender keeps offering, so the pipe backs up
  task automatic test_backpressure();
    logic [31:0] l;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req_cnt++;
    repeat (60) begin
      l = pick_operand();
      send_op(4'($urandom_range(15)), l, pick_partner(l));
    end
    stop_sending();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    wait_all_results();   // sender pauses until all results are back
    test_random(480, 0, 0);
    test_random(460, 55, 0);
    test_backpressure();
    test_random(460, 0, 55);
    test_random(460, 36, 36);
    wait_all_results();

    $display("sent %0d beats, checked %0d results: all opcodes, specials, subnormals,",
             n_sent, n_checked);
    $display("idle and stall mixes and a long output hold");
    if (n_errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/fcau_pkg.sv
rtl/fcau_unpack.sv
rtl/fcau_prep.sv
rtl/fcau_div_step.sv
rtl/fcau_align.sv
rtl/fcau_norm.sv
rtl/fcau_round.sv
rtl/float_compare_arith_unit.sv
tb/tb.sv
